/* sv/lav_pkg.sv */
// Shared types, constants and rounding functions of the look-at view matrix block.
`default_nettype none

package lav_pkg;

    localparam int IN_W      = 288;
    localparam int OUT_W     = 240;
    localparam int NV_W      = 49;
    localparam int SIDE_W    = 192;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 15;

    typedef logic signed [NV_W-1:0] nv_t;
    typedef logic [NV_W-1:0]        mag_t;
    typedef logic signed [15:0]     q14_t;
    typedef logic signed [31:0]     q16_t;
    typedef logic [SIDE_W-1:0]      side_t;

    // Negated dot product in Q18.30, rounded half away from zero to Q16.16 and saturated.
    function automatic q16_t neg_rnd_sat32(input logic signed [49:0] d);
        logic [49:0] mag;
        logic [35:0] r;
        q16_t        res;
        mag = d[49] ? 50'(-d) : 50'(d);
        r   = 36'((mag + 50'd8192) >> 14);
        if (d[49] || d == '0)
        begin
            res = (r > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : q16_t'(r[31:0]);
        end
        else
        begin
            res = (r >= 36'h0_8000_0000) ? 32'sh8000_0000 : q16_t'(-r[31:0]);
        end
        return res;
    endfunction

    // Q4.28 to Q2.14, rounded half away from zero and saturated.
    function automatic q14_t rnd_sat16(input logic signed [32:0] v);
        logic [32:0] mag;
        logic [18:0] r;
        q14_t        res;
        mag = v[32] ? 33'(-v) : 33'(v);
        r   = 19'((mag + 33'd8192) >> 14);
        if (v[32])
        begin
            res = (r >= 19'd32768) ? 16'sh8000 : q14_t'(-r[15:0]);
        end
        else
        begin
            res = (r > 19'd32767) ? 16'sh7FFF : q14_t'(r[15:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/lav_norm.sv */
// Pipelined normaliser of a signed vector to Q2.14 components (square root and divider stages).
`default_nettype none

module lav_norm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  lav_pkg::nv_t    in_vec [3],
    input  lav_pkg::side_t  in_side,
    output logic            out_valid,
    output lav_pkg::q14_t   out_vec [3],
    output lav_pkg::side_t  out_side
);
    import lav_pkg::*;

    localparam int SH_MAX = NV_W - 32;
    localparam int SH_W   = $clog2(SH_MAX + 1);
    localparam mag_t MAG_LIM = mag_t'(1) << 31;

    // Stage a: magnitudes and signs.
    logic        a_valid_reg;
    mag_t        a_mag_reg [3];
    logic [2:0]  a_neg_reg;
    side_t       a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= in_vec[i][NV_W-1] ? mag_t'(-in_vec[i]) : mag_t'(in_vec[i]);
                a_neg_reg[i] <= in_vec[i][NV_W-1];
            end
            a_side_reg <= in_side;
        end
    end

    // Stage b: the shift that brings the largest magnitude down to 2^31 or below.
    mag_t            b_mx;
    logic [SH_W-1:0] b_sh;

    always_comb
    begin
        b_mx = a_mag_reg[0];
        if (a_mag_reg[1] > b_mx)
            b_mx = a_mag_reg[1];
        if (a_mag_reg[2] > b_mx)
            b_mx = a_mag_reg[2];
        b_sh = '0;
        for (int s = SH_MAX; s >= 0; s--)
        begin
            if ((b_mx >> s) <= MAG_LIM)
                b_sh = SH_W'(s);
        end
    end

    logic            b_valid_reg;
    mag_t            b_mag_reg [3];
    logic [2:0]      b_neg_reg;
    logic [SH_W-1:0] b_sh_reg;
    side_t           b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_mag_reg  <= a_mag_reg;
            b_neg_reg  <= a_neg_reg;
            b_sh_reg   <= b_sh;
            b_side_reg <= a_side_reg;
        end
    end

    // Stage c: reduced magnitudes.
    logic        c_valid_reg;
    logic [31:0] c_m_reg [3];
    logic [2:0]  c_neg_reg;
    side_t       c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                c_m_reg[i] <= 32'(b_mag_reg[i] >> b_sh_reg);
            c_neg_reg  <= b_neg_reg;
            c_side_reg <= b_side_reg;
        end
    end

    // Stage d: squares.
    logic        d_valid_reg;
    logic [63:0] d_sq_reg [3];
    logic [31:0] d_m_reg [3];
    logic [2:0]  d_neg_reg;
    side_t       d_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                d_sq_reg[i] <= c_m_reg[i] * c_m_reg[i];
            d_m_reg    <= c_m_reg;
            d_neg_reg  <= c_neg_reg;
            d_side_reg <= c_side_reg;
        end
    end

    // Square root, one result bit per stage; entry 0 holds the sum of squares.
    logic        sq_valid_reg [SQ_STEPS+1];
    logic [63:0] sq_v_reg     [SQ_STEPS+1];
    logic [33:0] sq_rem_reg   [SQ_STEPS+1];
    logic [31:0] sq_root_reg  [SQ_STEPS+1];
    logic [31:0] sq_m_reg     [SQ_STEPS+1][3];
    logic [2:0]  sq_neg_reg   [SQ_STEPS+1];
    side_t       sq_side_reg  [SQ_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0]    <= d_sq_reg[0] + d_sq_reg[1] + d_sq_reg[2];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_m_reg[0]    <= d_m_reg;
            sq_neg_reg[0]  <= d_neg_reg;
            sq_side_reg[0] <= d_side_reg;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sq
        logic [35:0] r4;
        logic [35:0] tr;
        logic        ge;

        assign r4 = {sq_rem_reg[k], sq_v_reg[k][63:62]};
        assign tr = {2'b00, sq_root_reg[k], 2'b01};
        assign ge = (r4 >= tr);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[k+1]  <= ge ? 34'(r4 - tr) : r4[33:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][30:0], ge};
                sq_v_reg[k+1]    <= {sq_v_reg[k][61:0], 2'b00};
                sq_m_reg[k+1]    <= sq_m_reg[k];
                sq_neg_reg[k+1]  <= sq_neg_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // Divider set-up: numerator is m * 2^14 plus half the length, rounding to nearest.
    logic [31:0] f_len;
    logic [45:0] f_num [3];

    always_comb
    begin
        f_len = sq_root_reg[SQ_STEPS];
        for (int i = 0; i < 3; i++)
            f_num[i] = {sq_m_reg[SQ_STEPS][i], 14'b0} + {15'b0, f_len[31:1]};
    end

    logic                 dv_valid_reg [DIV_STEPS+1];
    logic [31:0]          dv_rem_reg   [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] dv_nb_reg    [DIV_STEPS+1][3];
    logic [DIV_STEPS-1:0] dv_q_reg     [DIV_STEPS+1][3];
    logic [31:0]          dv_len_reg   [DIV_STEPS+1];
    logic [2:0]           dv_neg_reg   [DIV_STEPS+1];
    side_t                dv_side_reg  [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= sq_valid_reg[SQ_STEPS];
    end

    // The quotient never exceeds 2^14, so the top numerator bits are already below the length.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= {1'b0, f_num[i][45:DIV_STEPS]};
                dv_nb_reg[0][i]  <= f_num[i][DIV_STEPS-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            dv_len_reg[0]  <= f_len;
            dv_neg_reg[0]  <= sq_neg_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_dv
        logic [32:0] tv [3];
        logic [2:0]  ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                tv[i] = {dv_rem_reg[k][i], dv_nb_reg[k][i][DIV_STEPS-1]};
                ge[i] = (tv[i] >= {1'b0, dv_len_reg[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[k+1][i] <= ge[i] ? 32'(tv[i] - {1'b0, dv_len_reg[k]})
                                                : tv[i][31:0];
                    dv_q_reg[k+1][i]   <= {dv_q_reg[k][i][DIV_STEPS-2:0], ge[i]};
                    dv_nb_reg[k+1][i]  <= {dv_nb_reg[k][i][DIV_STEPS-2:0], 1'b0};
                end
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // Final stage: sign and the zero-length case.
    logic  g_valid_reg;
    q14_t  g_vec_reg [3];
    side_t g_side_reg;
    q14_t  g_vec [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_len_reg[DIV_STEPS] == '0)
                g_vec[i] = '0;
            else if (dv_neg_reg[DIV_STEPS][i])
                g_vec[i] = q14_t'(-{1'b0, dv_q_reg[DIV_STEPS][i]});
            else
                g_vec[i] = q14_t'({1'b0, dv_q_reg[DIV_STEPS][i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (adv)
            g_valid_reg <= dv_valid_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_vec_reg  <= g_vec;
            g_side_reg <= dv_side_reg[DIV_STEPS];
        end
    end

    assign out_valid = g_valid_reg;
    assign out_vec   = g_vec_reg;
    assign out_side  = g_side_reg;

endmodule

`default_nettype wire

/* sv/look_at_view_matrix.sv */
// Top level of the look-at view matrix block: camera axes and translations from eye, forward, up.
// Throughput: one request per cycle; the pipeline moves as a whole whenever the output
// register is empty or its result is being taken.
// Each normaliser spends 32 stages on the square root and 15 on the divider.
// Reset (rst_n, asynchronous, active low) clears every valid bit; data registers are not reset.
`default_nettype none

module look_at_view_matrix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // eye_x, eye_y, eye_z, fwd_x, fwd_y, fwd_z, up_x, up_y, up_z (32 bits each)
    input  logic [lav_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // right_x/y/z, upward_x/y/z, view_x/y/z (16 bits each), shift_x/y/z (32 bits each)
    output logic [lav_pkg::OUT_W-1:0] m_tdata
);
    import lav_pkg::*;

    logic adv;
    logic o_valid_reg;

    assign adv      = !o_valid_reg || m_tready;
    assign s_tready = adv;

    // Input register.
    logic t0_valid_reg;
    q16_t t0_eye_reg [3];
    q16_t t0_fwd_reg [3];
    q16_t t0_up_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t0_valid_reg <= 1'b0;
        else if (adv)
            t0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t0_eye_reg[i] <= s_tdata[32*i +: 32];
                t0_fwd_reg[i] <= s_tdata[96 + 32*i +: 32];
                t0_up_reg[i]  <= s_tdata[192 + 32*i +: 32];
            end
        end
    end

    // z axis.
    nv_t   n1_in [3];
    side_t n1_side_in;
    logic  n1_valid;
    q14_t  n1_z [3];
    side_t n1_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n1_in[i] = {{(NV_W-32){t0_fwd_reg[i][31]}}, t0_fwd_reg[i]};
        n1_side_in = {t0_up_reg[2], t0_up_reg[1], t0_up_reg[0],
                      t0_eye_reg[2], t0_eye_reg[1], t0_eye_reg[0]};
    end

    lav_norm u_norm_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t0_valid_reg),
        .in_vec    (n1_in),
        .in_side   (n1_side_in),
        .out_valid (n1_valid),
        .out_vec   (n1_z),
        .out_side  (n1_side)
    );

    q16_t n1_eye [3];
    q16_t n1_up  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_eye[i] = n1_side[32*i +: 32];
            n1_up[i]  = n1_side[96 + 32*i +: 32];
        end
    end

    // cross(up, z) products, then differences.
    logic               t1_valid_reg;
    logic signed [47:0] t1_p_reg [6];
    q14_t               t1_z_reg [3];
    q16_t               t1_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t1_valid_reg <= 1'b0;
        else if (adv)
            t1_valid_reg <= n1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_p_reg[0] <= n1_up[1] * n1_z[2];
            t1_p_reg[1] <= n1_up[2] * n1_z[1];
            t1_p_reg[2] <= n1_up[2] * n1_z[0];
            t1_p_reg[3] <= n1_up[0] * n1_z[2];
            t1_p_reg[4] <= n1_up[0] * n1_z[1];
            t1_p_reg[5] <= n1_up[1] * n1_z[0];
            t1_z_reg    <= n1_z;
            t1_eye_reg  <= n1_eye;
        end
    end

    logic  t2_valid_reg;
    nv_t   t2_xr_reg [3];
    side_t t2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t2_valid_reg <= 1'b0;
        else if (adv)
            t2_valid_reg <= t1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                t2_xr_reg[i] <= {t1_p_reg[2*i][47], t1_p_reg[2*i]}
                              - {t1_p_reg[2*i+1][47], t1_p_reg[2*i+1]};
            t2_side_reg <= {48'b0, t1_z_reg[2], t1_z_reg[1], t1_z_reg[0],
                            t1_eye_reg[2], t1_eye_reg[1], t1_eye_reg[0]};
        end
    end

    // x axis.
    logic  n2_valid;
    q14_t  n2_x [3];
    side_t n2_side;

    lav_norm u_norm_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (t2_valid_reg),
        .in_vec    (t2_xr_reg),
        .in_side   (t2_side_reg),
        .out_valid (n2_valid),
        .out_vec   (n2_x),
        .out_side  (n2_side)
    );

    q16_t n2_eye [3];
    q14_t n2_z   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n2_eye[i] = n2_side[32*i +: 32];
            n2_z[i]   = n2_side[96 + 16*i +: 16];
        end
    end

    // p1: cross(z, x) products and the x and z dot products.
    logic               p1_valid_reg;
    logic signed [31:0] p1_yp_reg [6];
    logic signed [47:0] p1_dx_reg [3];
    logic signed [47:0] p1_dz_reg [3];
    q14_t               p1_x_reg [3];
    q14_t               p1_z_reg [3];
    q16_t               p1_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (adv)
            p1_valid_reg <= n2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_yp_reg[0] <= n2_z[1] * n2_x[2];
            p1_yp_reg[1] <= n2_z[2] * n2_x[1];
            p1_yp_reg[2] <= n2_z[2] * n2_x[0];
            p1_yp_reg[3] <= n2_z[0] * n2_x[2];
            p1_yp_reg[4] <= n2_z[0] * n2_x[1];
            p1_yp_reg[5] <= n2_z[1] * n2_x[0];
            for (int i = 0; i < 3; i++)
            begin
                p1_dx_reg[i] <= n2_x[i] * n2_eye[i];
                p1_dz_reg[i] <= n2_z[i] * n2_eye[i];
            end
            p1_x_reg   <= n2_x;
            p1_z_reg   <= n2_z;
            p1_eye_reg <= n2_eye;
        end
    end

    // p2: y axis and the x and z dot sums.
    logic               p2_valid_reg;
    q14_t               p2_y_reg [3];
    logic signed [49:0] p2_sx_reg;
    logic signed [49:0] p2_sz_reg;
    q14_t               p2_x_reg [3];
    q14_t               p2_z_reg [3];
    q16_t               p2_eye_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (adv)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                p2_y_reg[i] <= rnd_sat16({p1_yp_reg[2*i][31], p1_yp_reg[2*i]}
                                       - {p1_yp_reg[2*i+1][31], p1_yp_reg[2*i+1]});
            p2_sx_reg  <= 50'(p1_dx_reg[0]) + 50'(p1_dx_reg[1]) + 50'(p1_dx_reg[2]);
            p2_sz_reg  <= 50'(p1_dz_reg[0]) + 50'(p1_dz_reg[1]) + 50'(p1_dz_reg[2]);
            p2_x_reg   <= p1_x_reg;
            p2_z_reg   <= p1_z_reg;
            p2_eye_reg <= p1_eye_reg;
        end
    end

    // p3: y dot products and the x and z translations.
    logic               p3_valid_reg;
    logic signed [47:0] p3_dy_reg [3];
    q16_t               p3_shx_reg;
    q16_t               p3_shz_reg;
    q14_t               p3_x_reg [3];
    q14_t               p3_y_reg [3];
    q14_t               p3_z_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (adv)
            p3_valid_reg <= p2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                p3_dy_reg[i] <= p2_y_reg[i] * p2_eye_reg[i];
            p3_shx_reg <= neg_rnd_sat32(p2_sx_reg);
            p3_shz_reg <= neg_rnd_sat32(p2_sz_reg);
            p3_x_reg   <= p2_x_reg;
            p3_y_reg   <= p2_y_reg;
            p3_z_reg   <= p2_z_reg;
        end
    end

    // p4: y dot sum.
    logic               p4_valid_reg;
    logic signed [49:0] p4_sy_reg;
    q16_t               p4_shx_reg;
    q16_t               p4_shz_reg;
    q14_t               p4_x_reg [3];
    q14_t               p4_y_reg [3];
    q14_t               p4_z_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (adv)
            p4_valid_reg <= p3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_sy_reg  <= 50'(p3_dy_reg[0]) + 50'(p3_dy_reg[1]) + 50'(p3_dy_reg[2]);
            p4_shx_reg <= p3_shx_reg;
            p4_shz_reg <= p3_shz_reg;
            p4_x_reg   <= p3_x_reg;
            p4_y_reg   <= p3_y_reg;
            p4_z_reg   <= p3_z_reg;
        end
    end

    // Output register.
    q14_t o_right_reg  [3];
    q14_t o_upward_reg [3];
    q14_t o_view_reg   [3];
    q16_t o_shx_reg;
    q16_t o_shy_reg;
    q16_t o_shz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= p4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_right_reg  <= p4_x_reg;
            o_upward_reg <= p4_y_reg;
            o_view_reg   <= p4_z_reg;
            o_shx_reg    <= p4_shx_reg;
            o_shy_reg    <= neg_rnd_sat32(p4_sy_reg);
            o_shz_reg    <= p4_shz_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_shz_reg, o_shy_reg, o_shx_reg,
                       o_view_reg[2], o_view_reg[1], o_view_reg[0],
                       o_upward_reg[2], o_upward_reg[1], o_upward_reg[0],
                       o_right_reg[2], o_right_reg[1], o_right_reg[0]};

    // A zero view axis means a zero forward vector, which zeroes every other output.
    a_zero_view : assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_view_reg[0] == '0 && o_view_reg[1] == '0 && o_view_reg[2] == '0)
        |-> (o_right_reg[0] == '0 && o_right_reg[1] == '0 && o_right_reg[2] == '0 &&
             o_upward_reg[0] == '0 && o_upward_reg[1] == '0 && o_upward_reg[2] == '0 &&
             o_shx_reg == '0 && o_shy_reg == '0 && o_shz_reg == '0))
        else $error("zero view axis with non-zero outputs");

    // A zero x axis leaves the y axis and both of their translations zero.
    a_zero_right : assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_right_reg[0] == '0 && o_right_reg[1] == '0 && o_right_reg[2] == '0)
        |-> (o_upward_reg[0] == '0 && o_upward_reg[1] == '0 && o_upward_reg[2] == '0 &&
             o_shx_reg == '0 && o_shy_reg == '0))
        else $error("zero right axis with non-zero y axis or translation");

    // Normalised components never exceed one in magnitude.
    a_view_range : assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_view_reg[0] >= -16'sd16384 && o_view_reg[0] <= 16'sd16384 &&
                         o_view_reg[1] >= -16'sd16384 && o_view_reg[1] <= 16'sd16384 &&
                         o_view_reg[2] >= -16'sd16384 && o_view_reg[2] <= 16'sd16384))
        else $error("view axis component out of range");

    a_right_range : assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> (o_right_reg[0] >= -16'sd16384 && o_right_reg[0] <= 16'sd16384 &&
                         o_right_reg[1] >= -16'sd16384 && o_right_reg[1] <= 16'sd16384 &&
                         o_right_reg[2] >= -16'sd16384 && o_right_reg[2] <= 16'sd16384))
        else $error("right axis component out of range");

endmodule

`default_nettype wire

/* tb/sv/look_at_view_matrix_tb.sv */
// Self-checking testbench of the look-at view matrix block: directed table, then random cameras.
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

    import lav_pkg::*;

    typedef longint vec3_t [3];

    typedef struct {
        logic [IN_W-1:0]  req;
        bit               typed;
        logic [OUT_W-1:0] res;
    } row_t;

    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam int N_ROWS = 16;
    localparam int N_RANDOM = 440;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    logic [OUT_W-1:0] pending_views [$];
    int               mismatches;
    bit               calm;
    row_t             rows [N_ROWS];

    look_at_view_matrix u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b >>= 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_away(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic vec3_t unit_q14(vec3_t v);
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned len;
        vec3_t           n;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
        end
        forever
        begin
            mx = m[0];
            if (m[1] > mx) mx = m[1];
            if (m[2] > mx) mx = m[2];
            if (mx <= 64'h8000_0000) break;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
            begin
                n[i] = 0;
            end
            else
            begin
                mx = ((m[i] << 14) + (len >> 1)) / len;
                n[i] = (v[i] < 0) ? -longint'(mx) : longint'(mx);
            end
        end
        return n;
    endfunction

    function automatic vec3_t cross3(vec3_t a, vec3_t b);
        vec3_t c;
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
        return c;
    endfunction

    function automatic longint eye_shift(vec3_t ax, vec3_t eye);
        longint d;
        d = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
        return clamp(round_away(-d, 14), -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic logic [OUT_W-1:0] view_matrix(logic [IN_W-1:0] d);
        vec3_t eye, fwd, up, zx, xx, yx;
        logic [OUT_W-1:0] r;
        for (int i = 0; i < 3; i++)
        begin
            eye[i] = longint'($signed(d[32*i +: 32]));
            fwd[i] = longint'($signed(d[32*(3+i) +: 32]));
            up[i]  = longint'($signed(d[32*(6+i) +: 32]));
        end
        zx = unit_q14(fwd);
        xx = unit_q14(cross3(up, zx));
        yx = cross3(zx, xx);
        for (int i = 0; i < 3; i++)
        begin
            yx[i] = clamp(round_away(yx[i], 14), -32768, 32767);
            r[16*i +: 16]     = 16'(xx[i]);
            r[16*(3+i) +: 16] = 16'(yx[i]);
            r[16*(6+i) +: 16] = 16'(zx[i]);
        end
        r[144 +: 32] = 32'(eye_shift(xx, eye));
        r[176 +: 32] = 32'(eye_shift(yx, eye));
        r[208 +: 32] = 32'(eye_shift(zx, eye));
        return r;
    endfunction

    function automatic logic [IN_W-1:0] camera(logic [31:0] ex, logic [31:0] ey,
        logic [31:0] ez, logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
        logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
        return {uz, uy, ux, fz, fy, fx, ez, ey, ex};
    endfunction

    function automatic logic [OUT_W-1:0] matrix(logic [15:0] rx, logic [15:0] ry,
        logic [15:0] rz, logic [15:0] ux, logic [15:0] uy, logic [15:0] uz,
        logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
        logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
        return {sz, sy, sx, vz, vy, vx, uz, uy, ux, rz, ry, rx};
    endfunction

    // Mostly plausible camera coordinates, with zeros, extremes and raw words mixed in.
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return MAXV;
            2: return MINV;
            3, 4: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    task automatic send(logic [IN_W-1:0] req, bit typed, logic [OUT_W-1:0] res);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        pending_views.push_back(typed ? res : view_matrix(req));
        @(negedge clk);
    endtask

    // Result side: a random stall before each result is taken, except in calm phases.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        bit               bad;
        int               w;
        int               base;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = pending_views.pop_front();
                bad = 1'b0;
                for (int f = 0; f < 12; f++)
                begin
                    w    = (f < 9) ? 16 : 32;
                    base = (f < 9) ? 16 * f : 144 + 32 * (f - 9);
                    if (((want ^ m_tdata) >> base) & ((240'd1 << w) - 1))
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("field %0d: expected %h, got %h", f,
                                (want >> base) & ((240'd1 << w) - 1),
                                (m_tdata >> base) & ((240'd1 << w) - 1));
                    end
                end
                if (bad) mismatches++;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("look_at_view_matrix_tb: FAIL");
        $finish;
    end

    initial
    begin
        int waited;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatches = 0;
        calm = 1'b0;

        // Identity camera: forward along z, up along y.
        rows[0] = '{camera(0, 0, 0, 0, 0, ONE, 0, ONE, 0), 1,
                    matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0)};
        rows[1] = '{'0, 1, '0};
        // A zero forward vector clears everything, whatever the eye.
        rows[2] = '{camera(MAXV, MINV, ONE, 0, 0, 0, 0, ONE, 0), 1, '0};
        // Up parallel to forward: only the z axis and its translation survive.
        rows[3] = '{camera(ONE, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0), 1,
                    matrix(0, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0, -32'sd65536)};
        rows[4] = '{camera(0, 0, MAXV, 0, 0, ONE, 0, 0, 0), 0, '0};
        rows[5] = '{camera(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV), 0, '0};
        rows[6] = '{camera(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MINV), 0, '0};
        rows[7] = '{camera(MAXV, MINV, MAXV, 1, 0, 0, 0, 1, 0), 0, '0};
        rows[8] = '{camera(MINV, MAXV, MINV, MINV, 1, 0, 0, 0, MAXV), 0, '0};
        rows[9] = '{camera(ONE, 2 * ONE, -3 * ONE, ONE, ONE, ONE, 0, ONE, 0), 0, '0};
        rows[10] = '{camera(-ONE, ONE, ONE, -ONE, 0, ONE, ONE, ONE, 0), 0, '0};
        rows[11] = '{camera(0, 0, 0, 3, 4, 0, 0, 0, -1), 0, '0};
        rows[12] = '{camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           MAXV, 0, MINV, MINV, 0, MAXV), 0, '0};
        rows[13] = '{camera(MAXV, MAXV, MAXV, 0, 0, MINV, MINV, 0, 0), 0, '0};
        rows[14] = '{camera(12345, -54321, 777, -1, -1, -1, 1, -1, 1), 0, '0};
        rows[15] = '{camera(MINV, MINV, MINV, 0, MAXV, 0, 0, 0, ONE), 0, '0};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send(rows[i].req, rows[i].typed, rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            logic [IN_W-1:0] req;
            if (n % 60 == 0)
                calm = ($urandom_range(0, 2) == 0);
            req = camera(coord(), coord(), coord(), coord(), coord(), coord(),
                         coord(), coord(), coord());
            // Now and then make up equal to forward, so that the two are parallel.
            if ($urandom_range(0, 15) == 0)
                req[287:192] = req[191:96];
            send(req, 0, '0);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_views.size() != 0)
            @(posedge clk);
        waited = 0;
        while (waited < 130)
        begin
            @(posedge clk);
            waited++;
        end

        if (mismatches == 0)
            $display("look_at_view_matrix_tb: PASS");
        else
            $display("look_at_view_matrix_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/lav_pkg.sv
sv/lav_norm.sv
sv/look_at_view_matrix.sv
tb/sv/look_at_view_matrix_tb.sv
